[sv/bgid_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and threshold helpers for the blink gesture input decoder.
// No dependencies; every other file refers to this package by scoped names.

package bgid_pkg;

    localparam int COUNT_WIDTH     = 16;
    localparam int ENGLISH_LETTERS = 26;
    localparam int RUSSIAN_LETTERS = 33;

    localparam int CFG_WIDTH     = 7;
    localparam int CFG_IDX_WIDTH = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_val_t;

    localparam logic [6:0] ENGLISH_SIZE = 7'(ENGLISH_LETTERS);
    localparam logic [6:0] RUSSIAN_SIZE = 7'(RUSSIAN_LETTERS);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BLINK_FRAMES      = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LONG_CLOSE_FRAMES = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MOUSE_STEP        = 2'd2;

    localparam cfg_val_t BLINK_FRAMES_RST      = 7'd10;
    localparam cfg_val_t LONG_CLOSE_FRAMES_RST = 7'd30;
    localparam cfg_val_t MOUSE_STEP_RST        = 7'd10;

    // Item kinds on the input channel.
    localparam logic MODE_OBSERVE   = 1'b0;
    localparam logic MODE_FRAME_END = 1'b1;

    // Eye count codes.
    localparam logic [1:0] EYES_NONE = 2'd0;
    localparam logic [1:0] EYES_ONE  = 2'd1;
    localparam logic [1:0] EYES_TWO  = 2'd2;
    localparam logic [1:0] EYES_MANY = 2'd3;

    localparam logic [2:0] PANEL_LAST_MOUSE = 3'd6;
    localparam logic [2:0] PANEL_LAST_KBD   = 3'd3;

    typedef enum logic [3:0] {
        ACT_NONE       = 4'd0,
        ACT_TYPE       = 4'd1,
        ACT_BACKSPACE  = 4'd2,
        ACT_SPACE      = 4'd3,
        ACT_ENTER      = 4'd4,
        ACT_LCLICK     = 4'd5,
        ACT_RCLICK     = 4'd6,
        ACT_DBLCLICK   = 4'd7,
        ACT_MOVE_UP    = 4'd8,
        ACT_MOVE_DOWN  = 4'd9,
        ACT_MOVE_LEFT  = 4'd10,
        ACT_MOVE_RIGHT = 4'd11
    } action_t;

    typedef struct packed {
        logic        mode;
        logic [1:0]  eye_count;
        logic [11:0] face_center_x;
        logic [11:0] eye_center_x;
    } in_item_t;

    typedef struct packed {
        action_t     action;
        logic [5:0]  letter_index;
        logic        language;
        logic        input_mode;
        logic [2:0]  panel_index;
        logic [6:0]  move_distance;
        logic        last;
    } out_item_t;

    // Thresholds derived from the configuration registers.
    typedef struct packed {
        cfg_val_t blink;
        cfg_val_t long_close;
        cfg_val_t step;
        cfg_val_t reset_kbd;
        cfg_val_t reset_mouse;
        cfg_val_t retry_two;
        cfg_val_t retry_load;
        cfg_val_t kbd_blink;
        cfg_val_t mouse_blink;
        cfg_val_t long_open;
    } thr_t;

    // One decoded frame: up to two actions plus the state after the frame.
    typedef struct packed {
        action_t    act0;
        action_t    act1;
        logic       two_beats;
        logic [5:0] typed;
        logic [5:0] letter_pos;
        logic       language;
        logic       input_mode;
        logic [2:0] panel;
        cfg_val_t   step;
    } frame_rec_t;

    // Constant divisions by reciprocal multiplication; exact over the input ranges used.
    function automatic cfg_val_t div20(input logic [11:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd3277;
        return p[22:16];
    endfunction

    function automatic cfg_val_t div10(input logic [8:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd6554;
        return p[22:16];
    endfunction

    function automatic cfg_val_t div5(input logic [9:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd13108;
        return p[22:16];
    endfunction

    // ceil(0.75 g)
    function automatic cfg_val_t thr_reset_kbd(input cfg_val_t g);
        logic [8:0] s;
        s = 9'(g) * 9'd3 + 9'd3;
        return s[8:2];
    endfunction

    // ceil(0.85 g)
    function automatic cfg_val_t thr_085(input cfg_val_t g);
        return div20(12'(g) * 12'd17 + 12'd19);
    endfunction

    // ceil(0.8 g)
    function automatic cfg_val_t thr_080(input cfg_val_t g);
        return div5(10'(g) * 10'd4 + 10'd4);
    endfunction

    // ceil(0.35 g)
    function automatic cfg_val_t thr_035(input cfg_val_t g);
        return div20(12'(g) * 12'd7 + 12'd19);
    endfunction

    // ceil(0.3 g)
    function automatic cfg_val_t thr_030(input cfg_val_t g);
        return div10(9'(g) * 9'd3 + 9'd9);
    endfunction

    // ceil(0.2 g)
    function automatic cfg_val_t thr_020(input cfg_val_t g);
        return div5(10'(g) + 10'd4);
    endfunction

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == '1) ? v : v + cnt_t'(1);
    endfunction

endpackage

[sv/blink_gesture_input_decoder.sv]
`timescale 1ns / 1ps
// Top level of the blink gesture input decoder: configuration, front end, queue, output stage.
// Depends on bgid_pkg, bgid_cfg, bgid_front, bgid_fifo and bgid_back.
//
//   Channel    Handshake              Payload
//   request    req_valid / req_stall  req_data  (observation or frame end)
//   response   rsp_valid / rsp_stall  rsp_data  (one action beat)
//   config     cfg_wen                cfg_index, cfg_wdata
//
// One request is taken every cycle while the queue has room; observations update the
// counters on the edge they are accepted, and a frame end runs all decision rules then.
// A frame end leaves a record in a four-entry queue; the idle output stage then loads it
// into its register for the first beat, and beats leave one per cycle while rsp_stall is low.
// req_stall rises only while the queue is full, so response stalls reach the request side
// once four frames wait behind the one being sent. Reset clears counters, modes and queue.

module blink_gesture_input_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  bgid_pkg::in_item_t                  req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output bgid_pkg::out_item_t                 rsp_data,
    input  logic                                cfg_wen,
    input  logic [bgid_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  bgid_pkg::cfg_val_t                  cfg_wdata
);

    bgid_pkg::thr_t       thr;
    logic                 fifo_full;
    logic                 push;
    bgid_pkg::frame_rec_t push_rec;
    logic                 pop;
    logic                 head_valid;
    bgid_pkg::frame_rec_t head_rec;

    bgid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .thr       (thr)
    );

    bgid_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .thr       (thr),
        .fifo_full (fifo_full),
        .push      (push),
        .push_rec  (push_rec)
    );

    bgid_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    bgid_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data)
    );

endmodule

[sv/bgid_cfg.sv]
`timescale 1ns / 1ps
// Configuration registers and the frame-count thresholds derived from them.
// Depends on bgid_pkg.

module bgid_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wen,
    input  logic [bgid_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  bgid_pkg::cfg_val_t                    cfg_wdata,
    output bgid_pkg::thr_t                        thr
);

    bgid_pkg::thr_t thr_reg;
    bgid_pkg::thr_t thr_next;

    // Thresholds are worked out from the write data so they are ready on the next edge.
    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                bgid_pkg::REG_BLINK_FRAMES:
                begin
                    thr_next.blink       = cfg_wdata;
                    thr_next.reset_kbd   = bgid_pkg::thr_reset_kbd(cfg_wdata);
                    thr_next.reset_mouse = bgid_pkg::thr_085(cfg_wdata);
                    thr_next.retry_two   = bgid_pkg::thr_080(cfg_wdata);
                    thr_next.retry_load  = bgid_pkg::thr_035(cfg_wdata);
                    thr_next.kbd_blink   = bgid_pkg::thr_030(cfg_wdata);
                    thr_next.mouse_blink = bgid_pkg::thr_020(cfg_wdata);
                end
                bgid_pkg::REG_LONG_CLOSE_FRAMES:
                begin
                    thr_next.long_close = cfg_wdata;
                    thr_next.long_open  = bgid_pkg::thr_085(cfg_wdata);
                end
                bgid_pkg::REG_MOUSE_STEP:
                begin
                    thr_next.step = cfg_wdata;
                end
                default:
                begin
                    thr_next = thr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.blink       <= bgid_pkg::BLINK_FRAMES_RST;
            thr_reg.long_close  <= bgid_pkg::LONG_CLOSE_FRAMES_RST;
            thr_reg.step        <= bgid_pkg::MOUSE_STEP_RST;
            thr_reg.reset_kbd   <= bgid_pkg::thr_reset_kbd(bgid_pkg::BLINK_FRAMES_RST);
            thr_reg.reset_mouse <= bgid_pkg::thr_085(bgid_pkg::BLINK_FRAMES_RST);
            thr_reg.retry_two   <= bgid_pkg::thr_080(bgid_pkg::BLINK_FRAMES_RST);
            thr_reg.retry_load  <= bgid_pkg::thr_035(bgid_pkg::BLINK_FRAMES_RST);
            thr_reg.kbd_blink   <= bgid_pkg::thr_030(bgid_pkg::BLINK_FRAMES_RST);
            thr_reg.mouse_blink <= bgid_pkg::thr_020(bgid_pkg::BLINK_FRAMES_RST);
            thr_reg.long_open   <= bgid_pkg::thr_085(bgid_pkg::LONG_CLOSE_FRAMES_RST);
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign thr = thr_reg;

endmodule

[sv/bgid_front.sv]
`timescale 1ns / 1ps
// Front end: eye counters, gesture state and the frame-end decision rules.
// Produces one frame record per frame end. Depends on bgid_pkg.

module bgid_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  bgid_pkg::in_item_t      req_data,
    input  bgid_pkg::thr_t          thr,
    input  logic                    fifo_full,
    output logic                    push,
    output bgid_pkg::frame_rec_t    push_rec
);

    bgid_pkg::cnt_t z_reg, o_reg, t_reg, l_reg, r_reg;
    bgid_pkg::cnt_t z_next, o_next, t_next, l_next, r_next;
    logic [5:0]     letter_reg, letter_next;
    logic [2:0]     panel_reg, panel_next;
    logic           mouse_reg, mouse_next;
    logic           russian_reg, russian_next;

    logic           accept;
    logic           c_reset, c_retry, c_long, c_left, c_right;
    logic           blink_base, blink_ok;
    logic           lc_zero, retry_long_ok;
    bgid_pkg::cnt_t g_c, reset_thr_c, long_c, long_open_c, blink_load_c, retry_load_c;
    logic [5:0]     letter_inc;
    logic [6:0]     alpha_size;
    logic [2:0]     panel_kbd, panel_mouse;
    bgid_pkg::action_t act0, act1;
    logic           two_beats;

    assign req_stall = fifo_full;
    assign accept    = req_valid && !req_stall;

    assign g_c          = bgid_pkg::cnt_t'(thr.blink);
    assign long_c       = bgid_pkg::cnt_t'(thr.long_close);
    assign long_open_c  = bgid_pkg::cnt_t'(thr.long_open);
    assign retry_load_c = bgid_pkg::cnt_t'(thr.retry_load);
    assign reset_thr_c  = mouse_reg ? bgid_pkg::cnt_t'(thr.reset_mouse)
                                    : bgid_pkg::cnt_t'(thr.reset_kbd);
    assign blink_load_c = mouse_reg ? bgid_pkg::cnt_t'(thr.mouse_blink)
                                    : bgid_pkg::cnt_t'(thr.kbd_blink);

    assign lc_zero       = (thr.long_close == '0);
    assign retry_long_ok = (thr.retry_load <= thr.long_open);

    // The rules run in order, but each one that fires leaves the counters in a known
    // shape, so every condition can be decided from the counters at the frame end.
    // A blink cannot follow a reset, a retry or a long close, and left and right
    // blinks exclude each other.
    always_comb
    begin
        c_reset    = (t_reg >= reset_thr_c) && (o_reg < t_reg);
        blink_base = (o_reg >= g_c) && (o_reg > t_reg);
        c_retry    = !c_reset && blink_base &&
                     (t_reg >= bgid_pkg::cnt_t'(thr.retry_two));
        if (c_reset)
        begin
            c_long = lc_zero;
        end
        else if (c_retry)
        begin
            c_long = lc_zero && retry_long_ok;
        end
        else
        begin
            c_long = (z_reg >= long_c) && (o_reg <= long_open_c) && (t_reg <= long_open_c);
        end
        blink_ok = !c_reset && !c_retry && !c_long && blink_base;
        c_left   = blink_ok && (l_reg >= g_c) && (l_reg > r_reg);
        c_right  = blink_ok && (r_reg >= g_c) && (r_reg > l_reg);
    end

    assign letter_inc  = letter_reg + 6'd1;
    assign alpha_size  = russian_reg ? bgid_pkg::RUSSIAN_SIZE : bgid_pkg::ENGLISH_SIZE;
    assign panel_kbd   = (panel_reg > bgid_pkg::PANEL_LAST_KBD) ? bgid_pkg::PANEL_LAST_KBD
                                                                : panel_reg;
    assign panel_mouse = (panel_reg > bgid_pkg::PANEL_LAST_MOUSE) ? bgid_pkg::PANEL_LAST_MOUSE
                                                                  : panel_reg;

    always_comb
    begin
        z_next       = z_reg;
        o_next       = o_reg;
        t_next       = t_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        letter_next  = letter_reg;
        panel_next   = panel_reg;
        mouse_next   = mouse_reg;
        russian_next = russian_reg;
        act0         = bgid_pkg::ACT_NONE;
        act1         = bgid_pkg::ACT_NONE;
        two_beats    = 1'b0;

        if (accept && (req_data.mode == bgid_pkg::MODE_OBSERVE))
        begin
            unique case (req_data.eye_count)
                bgid_pkg::EYES_NONE:
                begin
                    z_next = bgid_pkg::sat_inc(z_reg);
                end
                bgid_pkg::EYES_ONE:
                begin
                    o_next = bgid_pkg::sat_inc(o_reg);
                    // An eye right on the face center counts for neither side.
                    if (req_data.face_center_x < req_data.eye_center_x)
                    begin
                        r_next = bgid_pkg::sat_inc(r_reg);
                    end
                    if (req_data.face_center_x > req_data.eye_center_x)
                    begin
                        l_next = bgid_pkg::sat_inc(l_reg);
                    end
                end
                bgid_pkg::EYES_TWO:
                begin
                    t_next = bgid_pkg::sat_inc(t_reg);
                end
                bgid_pkg::EYES_MANY:
                begin
                    z_next = bgid_pkg::cnt_t'(1);
                    o_next = bgid_pkg::cnt_t'(1);
                    t_next = bgid_pkg::cnt_t'(1);
                    l_next = bgid_pkg::cnt_t'(1);
                    r_next = bgid_pkg::cnt_t'(1);
                end
                default:
                begin
                    z_next = z_reg;
                end
            endcase
        end
        else if (accept)
        begin
            if (c_reset)
            begin
                z_next      = '0;
                o_next      = '0;
                t_next      = '0;
                l_next      = '0;
                r_next      = '0;
                letter_next = '0;
                panel_next  = '0;
            end
            if (c_retry)
            begin
                z_next = '0;
                o_next = retry_load_c;
                t_next = retry_load_c;
                l_next = retry_load_c;
                r_next = retry_load_c;
            end
            if (c_long)
            begin
                if (mouse_reg)
                begin
                    mouse_next = 1'b0;
                end
                else
                begin
                    russian_next = !russian_reg;
                end
                z_next      = '0;
                o_next      = '0;
                t_next      = '0;
                l_next      = '0;
                r_next      = '0;
                letter_next = '0;
                panel_next  = '0;
            end
            if (c_left)
            begin
                z_next = '0;
                o_next = blink_load_c;
                t_next = blink_load_c;
                l_next = blink_load_c;
                r_next = '0;
                if (!mouse_reg)
                begin
                    if (letter_reg != '0)
                    begin
                        act0      = bgid_pkg::ACT_BACKSPACE;
                        act1      = bgid_pkg::ACT_TYPE;
                        two_beats = 1'b1;
                    end
                    else
                    begin
                        act0 = bgid_pkg::ACT_TYPE;
                    end
                    letter_next = ({1'b0, letter_inc} >= alpha_size) ? 6'd0 : letter_inc;
                end
                else
                begin
                    act0 = bgid_pkg::action_t'(4'(bgid_pkg::ACT_LCLICK) + 4'(panel_mouse));
                end
            end
            if (c_right)
            begin
                z_next = '0;
                o_next = blink_load_c;
                t_next = blink_load_c;
                l_next = '0;
                r_next = blink_load_c;
                if (!mouse_reg)
                begin
                    unique case (panel_kbd)
                        3'd0:
                        begin
                            act0       = bgid_pkg::ACT_SPACE;
                            panel_next = 3'd1;
                        end
                        3'd1:
                        begin
                            act0       = bgid_pkg::ACT_BACKSPACE;
                            act1       = bgid_pkg::ACT_ENTER;
                            two_beats  = 1'b1;
                            panel_next = 3'd2;
                        end
                        3'd2:
                        begin
                            act0       = bgid_pkg::ACT_BACKSPACE;
                            act1       = bgid_pkg::ACT_BACKSPACE;
                            two_beats  = 1'b1;
                            panel_next = 3'd3;
                        end
                        default:
                        begin
                            panel_next = 3'd0;
                            mouse_next = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    panel_next = (panel_reg >= bgid_pkg::PANEL_LAST_MOUSE) ? 3'd0
                                                                           : panel_reg + 3'd1;
                end
            end
        end
    end

    assign push = accept && (req_data.mode == bgid_pkg::MODE_FRAME_END);

    always_comb
    begin
        push_rec.act0       = act0;
        push_rec.act1       = act1;
        push_rec.two_beats  = two_beats;
        push_rec.typed      = letter_reg;
        push_rec.letter_pos = letter_next;
        push_rec.language   = russian_next;
        push_rec.input_mode = mouse_next;
        push_rec.panel      = panel_next;
        push_rec.step       = thr.step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_reg       <= '0;
            o_reg       <= '0;
            t_reg       <= '0;
            l_reg       <= '0;
            r_reg       <= '0;
            letter_reg  <= '0;
            panel_reg   <= '0;
            mouse_reg   <= 1'b0;
            russian_reg <= 1'b0;
        end
        else
        begin
            z_reg       <= z_next;
            o_reg       <= o_next;
            t_reg       <= t_next;
            l_reg       <= l_next;
            r_reg       <= r_next;
            letter_reg  <= letter_next;
            panel_reg   <= panel_next;
            mouse_reg   <= mouse_next;
            russian_reg <= russian_next;
        end
    end

endmodule

[sv/bgid_fifo.sv]
`timescale 1ns / 1ps
// Short queue of frame records between the front end and the output stage.
// Depends on bgid_pkg.

module bgid_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  bgid_pkg::frame_rec_t    push_rec,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output bgid_pkg::frame_rec_t    head_rec
);

    bgid_pkg::frame_rec_t entries_reg [bgid_pkg::FIFO_DEPTH];

    logic [bgid_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bgid_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bgid_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == bgid_pkg::FIFO_CNT_W'(bgid_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + bgid_pkg::FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + bgid_pkg::FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + bgid_pkg::FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - bgid_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

[sv/bgid_back.sv]
`timescale 1ns / 1ps
// Output stage: holds one frame record and sends it as one or two result beats.
// Depends on bgid_pkg.

module bgid_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  bgid_pkg::frame_rec_t    head_rec,
    output logic                    pop,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output bgid_pkg::out_item_t     rsp_data
);

    bgid_pkg::frame_rec_t rec_reg, rec_next;
    logic                 rec_valid_reg, rec_valid_next;
    logic                 beat_reg, beat_next;

    logic                 beat_done;
    logic                 is_last;
    logic                 take;
    bgid_pkg::action_t    cur_act;

    assign is_last   = !rec_reg.two_beats || beat_reg;
    assign beat_done = rec_valid_reg && !rsp_stall;
    // A new record loads on the same edge that the last beat of the old one leaves.
    assign take      = !rec_valid_reg || (beat_done && is_last);
    assign pop       = take && head_valid;

    always_comb
    begin
        rec_next       = rec_reg;
        rec_valid_next = rec_valid_reg;
        beat_next      = beat_reg;
        if (take)
        begin
            rec_next       = head_rec;
            rec_valid_next = head_valid;
            beat_next      = 1'b0;
        end
        else if (beat_done)
        begin
            beat_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
            beat_reg      <= 1'b0;
        end
        else
        begin
            rec_valid_reg <= rec_valid_next;
            beat_reg      <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign cur_act   = beat_reg ? rec_reg.act1 : rec_reg.act0;
    assign rsp_valid = rec_valid_reg;

    always_comb
    begin
        rsp_data.action        = cur_act;
        rsp_data.letter_index  = (cur_act == bgid_pkg::ACT_TYPE) ? rec_reg.typed
                                                                 : rec_reg.letter_pos;
        rsp_data.language      = rec_reg.language;
        rsp_data.input_mode    = rec_reg.input_mode;
        rsp_data.panel_index   = rec_reg.panel;
        rsp_data.move_distance = (4'(cur_act) >= 4'(bgid_pkg::ACT_MOVE_UP)) ? rec_reg.step
                                                                            : 7'd0;
        rsp_data.last          = is_last;
    end

endmodule
